// File: design/tsq_pkg.sv
// tsq_pkg: types, angle constants and arctangent table for the thick segment quad
// used by tsq_cordic_stage and thick_segment_quad_with_axis_snap
package tsq_pkg;

  localparam int COORD_BITS = 16;
  localparam int VEC_SHIFT  = 46 - COORD_BITS;
  localparam int DW         = 50;   // cordic x/y datapath width
  localparam int ZW         = 35;   // angle width, 2^30 per radian
  localparam int QW         = 18;   // q1.15 unit vector, holds +-32768

  localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_DEG5    = 35'sd93701651;
  localparam logic signed [ZW-1:0] ANG_DEG85   = 35'sd1592928067;
  localparam logic signed [ZW-1:0] ANG_DEG95   = 35'sd1780331369;
  localparam logic signed [ZW-1:0] ANG_DEG175  = 35'sd3279557785;
  localparam logic signed [DW-1:0] INV_GAIN    = 50'sd652032874;
  localparam logic signed [QW-1:0] Q15_ONE     = 18'sd32768;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
    logic                         snapped;
  } quad_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0:  r = 35'sd843314857;
        1:  r = 35'sd497837829;
        2:  r = 35'sd263043837;
        3:  r = 35'sd133525159;
        4:  r = 35'sd67021687;
        5:  r = 35'sd33543516;
        6:  r = 35'sd16775851;
        7:  r = 35'sd8388437;
        8:  r = 35'sd4194283;
        9:  r = 35'sd2097149;
        10: r = 35'sd1048576;
        11: r = 35'sd524288;
        12: r = 35'sd262144;
        13: r = 35'sd131072;
        14: r = 35'sd65536;
        15: r = 35'sd32768;
        16: r = 35'sd16384;
        17: r = 35'sd8192;
        18: r = 35'sd4096;
        19: r = 35'sd2048;
        20: r = 35'sd1024;
        21: r = 35'sd512;
        22: r = 35'sd256;
        23: r = 35'sd128;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [17:0] v);
    logic signed [COORD_BITS-1:0] r;
    begin
      if (v > 18'sd32767) begin
        r = 16'sd32767;
      end else if (v < -18'sd32768) begin
        r = -16'sd32768;
      end else begin
        r = v[COORD_BITS-1:0];
      end
      return r;
    end
  endfunction

endpackage

// File: design/tsq_cordic_stage.sv
// tsq_cordic_stage: one cordic micro-rotation, vectoring or rotation mode
// depends on tsq_pkg for the datapath struct and the arctangent table
module tsq_cordic_stage #(
  parameter int SHIFT  = 0,
  parameter bit ROTATE = 1'b0
) (
  input  tsq_pkg::rot_t a,
  output tsq_pkg::rot_t b
);

  logic                          up;
  logic signed [tsq_pkg::DW-1:0] xs;
  logic signed [tsq_pkg::DW-1:0] ys;
  logic signed [tsq_pkg::ZW-1:0] ang;

  assign ang = tsq_pkg::atan_entry(SHIFT);
  // rotation steers on the residual angle, vectoring on the sign of y
  assign up  = ROTATE ? !a.z[tsq_pkg::ZW-1] : a.y[tsq_pkg::DW-1];
  assign xs  = a.x >>> SHIFT;
  assign ys  = a.y >>> SHIFT;

  always_comb begin
    if (up) begin
      b.x = a.x - ys;
      b.y = a.y + xs;
      b.z = a.z - ang;
    end else begin
      b.x = a.x + ys;
      b.y = a.y - xs;
      b.z = a.z + ang;
    end
  end

endmodule

// File: design/thick_segment_quad_with_axis_snap.sv
// thick_segment_quad_with_axis_snap: rectangle corners around a segment, axis snap
// depends on tsq_pkg and tsq_cordic_stage
//
//  channel | signals                     | direction | payload
//  seg     | seg_valid seg_stall seg     | in        | tsq_pkg::seg_t
//  quad    | quad_valid quad_stall quad  | out       | tsq_pkg::quad_t
//  cfg     | cfg_we cfg_wdata            | in        | wall_width, 12 bit
//
// one request per cycle while quad is not stalled; two cordic chains, with
// one stage per micro-rotation
// rst is synchronous: all valid bits clear, wall_width returns to 160
// a stall on quad while quad_valid is high freezes the whole pipeline; seg_stall follows it directly
module thick_segment_quad_with_axis_snap #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           seg_valid,
  output logic           seg_stall,
  input  tsq_pkg::seg_t  seg,
  output logic           quad_valid,
  input  logic           quad_stall,
  output tsq_pkg::quad_t quad,
  input  logic           cfg_we,
  input  logic [11:0]    cfg_wdata
);

  localparam int N = CORDIC_STEPS;

  typedef struct packed {
    tsq_pkg::seg_t seg;
    logic          zero_len;
    tsq_pkg::rot_t r;
  } vec_t;

  typedef struct packed {
    tsq_pkg::seg_t                 seg;   // end point already snapped
    logic                          snap;
    logic signed [tsq_pkg::QW-1:0] c;
    logic signed [tsq_pkg::QW-1:0] s;
    logic                          flip;
    tsq_pkg::rot_t                 r;
  } rstg_t;

  typedef struct packed {
    tsq_pkg::seg_t                 seg;
    logic                          snap;
    logic signed [tsq_pkg::QW-1:0] c;
    logic signed [tsq_pkg::QW-1:0] s;
  } unit_t;

  typedef struct packed {
    tsq_pkg::seg_t seg;
    logic          snap;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } off_t;

  logic [11:0] wall_width;
  logic        adv;

  // global advance: everything moves unless a finished result is held
  assign adv       = !(quad_valid && quad_stall);
  assign seg_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      wall_width <= 12'd160;
    end else if (cfg_we) begin
      wall_width <= cfg_wdata;
    end
  end

  // ---------------- setup: difference vector, half-plane fold ----------------
  logic signed [16:0]             dx;
  logic signed [16:0]             dy;
  logic signed [tsq_pkg::DW-1:0]  sdx;
  logic signed [tsq_pkg::DW-1:0]  sdy;
  vec_t                           setup;

  assign dx  = 17'(seg.end_x) - 17'(seg.start_x);
  assign dy  = 17'(seg.end_y) - 17'(seg.start_y);
  assign sdx = tsq_pkg::DW'(dx) <<< tsq_pkg::VEC_SHIFT;
  assign sdy = tsq_pkg::DW'(dy) <<< tsq_pkg::VEC_SHIFT;

  always_comb begin
    setup.seg      = seg;
    setup.zero_len = (dx == 17'sd0) && (dy == 17'sd0);
    if (sdx[tsq_pkg::DW-1]) begin
      // left half plane: start at +-pi and mirror the vector
      setup.r.x = -sdx;
      setup.r.y = -sdy;
      setup.r.z = sdy[tsq_pkg::DW-1] ? -tsq_pkg::ANG_PI : tsq_pkg::ANG_PI;
    end else begin
      setup.r.x = sdx;
      setup.r.y = sdy;
      setup.r.z = '0;
    end
  end

  // ---------------- vectoring chain ----------------
  vec_t          vp   [0:N];
  tsq_pkg::rot_t vnext[0:N-1];
  logic [N:0]    vv;

  for (genvar i = 0; i < N; i++) begin : g_vec
    tsq_cordic_stage #(.SHIFT(i), .ROTATE(1'b0)) u_stage (
      .a(vp[i].r),
      .b(vnext[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vv <= '0;
    end else if (adv) begin
      vv <= {vv[N-1:0], seg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vp[0] <= setup;
      for (int i = 0; i < N; i++) begin
        vp[i+1].seg      <= vp[i].seg;
        vp[i+1].zero_len <= vp[i].zero_len;
        vp[i+1].r        <= vnext[i];
      end
    end
  end

  // ---------------- classify: axis snap and rotation setup ----------------
  logic signed [tsq_pkg::ZW-1:0] za;
  rstg_t                         cls;

  assign za = vp[N].r.z;

  always_comb begin
    cls.seg  = vp[N].seg;
    cls.snap = 1'b1;
    cls.c    = '0;
    cls.s    = '0;
    cls.flip = 1'b0;
    cls.r.x  = tsq_pkg::INV_GAIN;
    cls.r.y  = '0;
    cls.r.z  = za;
    if (vp[N].zero_len) begin
      // zero length counts as straight up
      cls.s         = tsq_pkg::Q15_ONE;
      cls.seg.end_x = vp[N].seg.start_x;
    end else if (za > -tsq_pkg::ANG_DEG5 && za < tsq_pkg::ANG_DEG5) begin
      cls.c         = tsq_pkg::Q15_ONE;
      cls.seg.end_y = vp[N].seg.start_y;
    end else if (za > tsq_pkg::ANG_DEG85 && za < tsq_pkg::ANG_DEG95) begin
      cls.s         = tsq_pkg::Q15_ONE;
      cls.seg.end_x = vp[N].seg.start_x;
    end else if (za > tsq_pkg::ANG_DEG175 || za < -tsq_pkg::ANG_DEG175) begin
      cls.c         = -tsq_pkg::Q15_ONE;
      cls.seg.end_y = vp[N].seg.start_y;
    end else if (za > -tsq_pkg::ANG_DEG95 && za < -tsq_pkg::ANG_DEG85) begin
      cls.s         = -tsq_pkg::Q15_ONE;
      cls.seg.end_x = vp[N].seg.start_x;
    end else begin
      cls.snap = 1'b0;
      // fold into +-90 degrees, undo with a sign flip at the end
      if (za > tsq_pkg::ANG_HALF_PI) begin
        cls.r.z  = za - tsq_pkg::ANG_PI;
        cls.flip = 1'b1;
      end else if (za < -tsq_pkg::ANG_HALF_PI) begin
        cls.r.z  = za + tsq_pkg::ANG_PI;
        cls.flip = 1'b1;
      end
    end
  end

  // ---------------- rotation chain ----------------
  rstg_t         rp   [0:N];
  tsq_pkg::rot_t rnext[0:N-1];
  logic [N:0]    rv;

  for (genvar i = 0; i < N; i++) begin : g_rot
    tsq_cordic_stage #(.SHIFT(i), .ROTATE(1'b1)) u_stage (
      .a(rp[i].r),
      .b(rnext[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= '0;
    end else if (adv) begin
      rv <= {rv[N-1:0], vv[N]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp[0] <= cls;
      for (int i = 0; i < N; i++) begin
        rp[i+1].seg  <= rp[i].seg;
        rp[i+1].snap <= rp[i].snap;
        rp[i+1].c    <= rp[i].c;
        rp[i+1].s    <= rp[i].s;
        rp[i+1].flip <= rp[i].flip;
        rp[i+1].r    <= rnext[i];
      end
    end
  end

  // ---------------- round to q1.15 ----------------
  logic signed [tsq_pkg::DW-1:0] fx;
  logic signed [tsq_pkg::DW-1:0] fy;
  logic signed [tsq_pkg::DW-1:0] rx;
  logic signed [tsq_pkg::DW-1:0] ry;
  unit_t                         unit_next;
  unit_t                         ur;
  logic                          uv;

  assign fx = rp[N].flip ? -rp[N].r.x : rp[N].r.x;
  assign fy = rp[N].flip ? -rp[N].r.y : rp[N].r.y;
  assign rx = (fx + tsq_pkg::DW'(16384)) >>> 15;
  assign ry = (fy + tsq_pkg::DW'(16384)) >>> 15;

  always_comb begin
    unit_next.seg  = rp[N].seg;
    unit_next.snap = rp[N].snap;
    if (rp[N].snap) begin
      unit_next.c = rp[N].c;
      unit_next.s = rp[N].s;
    end else begin
      if (rx > tsq_pkg::DW'(tsq_pkg::Q15_ONE)) begin
        unit_next.c = tsq_pkg::Q15_ONE;
      end else if (rx < -tsq_pkg::DW'(tsq_pkg::Q15_ONE)) begin
        unit_next.c = -tsq_pkg::Q15_ONE;
      end else begin
        unit_next.c = rx[tsq_pkg::QW-1:0];
      end
      if (ry > tsq_pkg::DW'(tsq_pkg::Q15_ONE)) begin
        unit_next.s = tsq_pkg::Q15_ONE;
      end else if (ry < -tsq_pkg::DW'(tsq_pkg::Q15_ONE)) begin
        unit_next.s = -tsq_pkg::Q15_ONE;
      end else begin
        unit_next.s = ry[tsq_pkg::QW-1:0];
      end
    end
  end

  // ---------------- half-width offset multiply ----------------
  logic signed [12:0] ws;
  logic signed [30:0] px;
  logic signed [30:0] py;
  logic signed [30:0] pxr;
  logic signed [30:0] pyr;
  off_t               off_next;
  off_t               mr;
  logic               mv;

  assign ws  = $signed({1'b0, wall_width});
  // operands widened first so the product cannot wrap
  assign px  = -(31'(ws) * 31'(ur.s));
  assign py  = 31'(ws) * 31'(ur.c);
  assign pxr = (px + 31'sd32768) >>> 16;
  assign pyr = (py + 31'sd32768) >>> 16;

  always_comb begin
    off_next.seg  = ur.seg;
    off_next.snap = ur.snap;
    off_next.ox   = pxr[15:0];
    off_next.oy   = pyr[15:0];
  end

  // ---------------- corners with saturation ----------------
  tsq_pkg::quad_t quad_next;
  logic signed [17:0] sx;
  logic signed [17:0] sy;
  logic signed [17:0] ex;
  logic signed [17:0] ey;
  logic signed [17:0] ox;
  logic signed [17:0] oy;

  assign sx = 18'(mr.seg.start_x);
  assign sy = 18'(mr.seg.start_y);
  assign ex = 18'(mr.seg.end_x);
  assign ey = 18'(mr.seg.end_y);
  assign ox = 18'(mr.ox);
  assign oy = 18'(mr.oy);

  always_comb begin
    quad_next.corner0_x = tsq_pkg::sat_coord(sx + ox);
    quad_next.corner0_y = tsq_pkg::sat_coord(sy + oy);
    quad_next.corner1_x = tsq_pkg::sat_coord(sx - ox);
    quad_next.corner1_y = tsq_pkg::sat_coord(sy - oy);
    quad_next.corner2_x = tsq_pkg::sat_coord(ex - ox);
    quad_next.corner2_y = tsq_pkg::sat_coord(ey - oy);
    quad_next.corner3_x = tsq_pkg::sat_coord(ex + ox);
    quad_next.corner3_y = tsq_pkg::sat_coord(ey + oy);
    quad_next.snapped   = mr.snap;
  end

  // tail stages: round, multiply, output
  always_ff @(posedge clk) begin
    if (rst) begin
      uv         <= 1'b0;
      mv         <= 1'b0;
      quad_valid <= 1'b0;
    end else if (adv) begin
      uv         <= rv[N];
      mv         <= uv;
      quad_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ur   <= unit_next;
      mr   <= off_next;
      quad <= quad_next;
    end
  end

  // ---------------- assertions ----------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !seg_stall) |=> vv[0])
    else $error("accepted request did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (quad_valid && quad_stall) |=> ($stable(vv) && $stable(rv) && $stable(mv)))
    else $error("pipeline moved during an output stall");

  a_zero_len_snaps: assert property (@(posedge clk) disable iff (rst)
    (vv[N] && vp[N].zero_len) |-> cls.snap)
    else $error("zero length segment not snapped");

endmodule

// File: test/tb.sv
// tb: self-checking regression for thick_segment_quad_with_axis_snap
// depends on tsq_pkg and the design files; predicts each quad with its own cordic model
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 4;
  localparam longint ANG_PI_L = 64'sd3373259426;
  localparam longint ANG_HALF_L = 64'sd1686629713;
  localparam longint DEG5_L = 64'sd93701651;
  localparam longint INV_GAIN_L = 64'sd652032874;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic seg_valid = 1'b0;
  logic seg_stall;
  tsq_pkg::seg_t seg = '0;
  logic quad_valid;
  logic quad_stall = 1'b0;
  tsq_pkg::quad_t quad;
  logic cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  // requests waiting for the driver, and quads predicted for each accepted request
  tsq_pkg::seg_t seg_pending[$];
  tsq_pkg::quad_t quad_expected[$];
  logic [11:0] width_model = 12'd160;
  int errors = 0;
  int cycle_count = 0;
  bit calm = 1'b0;        // stretch with no idling on either side
  int hold_cycles = 0;    // long receiver hold-off, counted down in the monitor
  bit hold_req = 1'b0;

  thick_segment_quad_with_axis_snap #(.CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst), .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
    .quad_valid(quad_valid), .quad_stall(quad_stall), .quad(quad),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic longint atan_val(int i);
    longint t[24] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    return t[i];
  endfunction

  function automatic longint round_q15(longint v);
    longint r;
    r = floor_shr(v + 16384, 15);
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  // segment direction angle, 2^30 per radian
  function automatic longint seg_angle(longint dx, longint dy);
    longint x, y, z, nx, ny;
    x = dx <<< tsq_pkg::VEC_SHIFT;
    y = dy <<< tsq_pkg::VEC_SHIFT;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? ANG_PI_L : -ANG_PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_val(i);
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_val(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic tsq_pkg::quad_t predict_quad(tsq_pkg::seg_t s_in, logic [11:0] w12);
    tsq_pkg::quad_t q;
    longint sx, sy, ex, ey, dx, dy, c, s, z, x, y, nx, ny, ox, oy, w;
    bit flip;
    bit snap;
    sx = longint'(s_in.start_x); sy = longint'(s_in.start_y);
    ex = longint'(s_in.end_x); ey = longint'(s_in.end_y);
    dx = ex - sx; dy = ey - sy;
    c = 0; s = 0; w = longint'(w12); snap = 1'b1;
    if (dx == 0 && dy == 0) begin
      // zero length counts as pointing up
      s = 32768; ex = sx;
    end else begin
      z = seg_angle(dx, dy);
      if (z > -DEG5_L && z < DEG5_L) begin
        c = 32768; ey = sy;
      end else if (z > 17 * DEG5_L && z < 19 * DEG5_L) begin
        s = 32768; ex = sx;
      end else if (z > 35 * DEG5_L || z < -35 * DEG5_L) begin
        c = -32768; ey = sy;
      end else if (z > -19 * DEG5_L && z < -17 * DEG5_L) begin
        s = -32768; ex = sx;
      end else begin
        snap = 1'b0;
        flip = 1'b0;
        if (z > ANG_HALF_L) begin
          z -= ANG_PI_L; flip = 1'b1;
        end else if (z < -ANG_HALF_L) begin
          z += ANG_PI_L; flip = 1'b1;
        end
        x = INV_GAIN_L; y = 0;
        for (int i = 0; i < STEPS; i++) begin
          if (z >= 0) begin
            nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_val(i);
          end else begin
            nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_val(i);
          end
          x = nx; y = ny;
        end
        if (flip) begin
          x = -x; y = -y;
        end
        c = round_q15(x); s = round_q15(y);
      end
    end
    ox = floor_shr(w * -s + 32768, 16);
    oy = floor_shr(w * c + 32768, 16);
    q.corner0_x = clamp16(sx + ox); q.corner0_y = clamp16(sy + oy);
    q.corner1_x = clamp16(sx - ox); q.corner1_y = clamp16(sy - oy);
    q.corner2_x = clamp16(ex - ox); q.corner2_y = clamp16(ey - oy);
    q.corner3_x = clamp16(ex + ox); q.corner3_y = clamp16(ey + oy);
    q.snapped = snap;
    return q;
  endfunction

  // driver: offers the oldest pending request, idles now and then
  always @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else begin
      if (seg_valid && !seg_stall) begin
        quad_expected.push_back(predict_quad(seg, width_model));
        void'(seg_pending.pop_front());
      end
      if (seg_valid && seg_stall) begin
        // payload held while stalled
      end else if (seg_pending.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        seg_valid <= 1'b1;
        seg <= seg_pending[0];
      end else begin
        seg_valid <= 1'b0;
      end
    end
  end

  // monitor: stalls at random or for a long hold-off, checks each accepted quad
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("thick_segment_quad_with_axis_snap regression: fail");
      $finish;
    end
    if (!rst) begin
      if (quad_valid && !quad_stall) begin
        if (quad_expected.size() == 0) begin
          $display("%0t unexpected quad %h", $time, quad);
          errors++;
        end else begin
          if (quad !== quad_expected[0]) begin
            $display("%0t quad mismatch expected %h actual %h", $time, quad_expected[0], quad);
            if (quad.snapped !== quad_expected[0].snapped)
              $display("%0t snapped expected %0d actual %0d", $time,
                       quad_expected[0].snapped, quad.snapped);
            errors++;
          end
          void'(quad_expected.pop_front());
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        quad_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_cycles <= 300;
        quad_stall <= 1'b1;
      end else begin
        quad_stall <= !calm && ($urandom_range(99) < 7);
      end
    end
  end

  function automatic tsq_pkg::seg_t rand_seg();
    tsq_pkg::seg_t s;
    int r;
    s.start_x = 16'($urandom); s.start_y = 16'($urandom);
    r = $urandom_range(9);
    // mix of near-axis segments, short ones, and full range noise
    if (r < 3) begin
      s.end_x = s.start_x + $signed(16'($urandom_range(4000)) - 16'sd2000);
      s.end_y = s.start_y + $signed(16'($urandom_range(300)) - 16'sd150);
    end else if (r < 6) begin
      s.end_y = s.start_y + $signed(16'($urandom_range(4000)) - 16'sd2000);
      s.end_x = s.start_x + $signed(16'($urandom_range(300)) - 16'sd150);
    end else if (r < 7) begin
      s.end_x = s.start_x + $signed(16'($urandom_range(6)) - 16'sd3);
      s.end_y = s.start_y + $signed(16'($urandom_range(6)) - 16'sd3);
    end else begin
      s.end_x = 16'($urandom); s.end_y = 16'($urandom);
    end
    return s;
  endfunction

  task automatic push_seg(int sx, int sy, int ex, int ey);
    tsq_pkg::seg_t s;
    s.start_x = 16'(sx); s.start_y = 16'(sy); s.end_x = 16'(ex); s.end_y = 16'(ey);
    seg_pending.push_back(s);
  endtask

  task automatic drain_all();
    while (seg_pending.size() > 0 || seg_valid || quad_expected.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_width(logic [11:0] w);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_model = w;
  endtask

  initial begin
    logic [11:0] widths[5] = '{12'd4095, 12'd0, 12'd1, 12'd2048, 12'd777};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: reset width, zero length, axes, near thresholds, diagonals, extremes
    calm = 1'b1;
    push_seg(0, 0, 0, 0);
    push_seg(100, 100, 500, 100);
    push_seg(100, 100, -500, 100);
    push_seg(100, 100, 100, 500);
    push_seg(100, 100, 100, -500);
    push_seg(0, 0, -1000, 0);
    push_seg(0, 0, -1000, -1);
    push_seg(0, 0, 1000, 87);
    push_seg(0, 0, 1000, 88);
    push_seg(0, 0, 1000, 1000);
    push_seg(0, 0, -1000, 1000);
    push_seg(0, 0, -1000, -1000);
    push_seg(0, 0, 1000, -1000);
    push_seg(32767, 32767, 32767, -32768);
    push_seg(-32768, -32768, 32767, 32767);
    push_seg(32767, -32768, -32768, 32767);
    push_seg(32767, 32767, 32767, 32767);
    push_seg(-32768, 0, -32768, 0);
    push_seg(-32768, -32768, -32768, 32767);
    push_seg(0, 0, 3, 1);
    drain_all();
    write_width(12'd4095);
    push_seg(32767, 32767, 32767, -32768);
    push_seg(-32768, -32768, -30000, -32768);
    push_seg(-5, 7, 1200, 2900);
    drain_all();
    calm = 1'b0;
    // random phases over several widths, one with a long receiver hold-off
    for (int p = 0; p < 5; p++) begin
      write_width(widths[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == 3) calm = 1'b1;
      for (int i = 0; i < 310; i++) seg_pending.push_back(rand_seg());
      drain_all();
      calm = 1'b0;
    end
    if (errors == 0) begin
      $display("thick_segment_quad_with_axis_snap regression: pass");
    end else begin
      $display("thick_segment_quad_with_axis_snap regression: fail");
    end
    $finish;
  end
endmodule
